[hw/rtl/spq_pkg.sv]
// Shared types, codes and the priority function for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.

package spq_pkg;

  localparam logic       FUNC_ENQ = 1'b0;
  localparam logic       FUNC_DEQ = 1'b1;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_AGILE = 2'd1;
  localparam logic [1:0] KIND_TANK  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int HANDLE_W = 16;
  localparam int PRIO_W   = 12;

  typedef struct packed {
    logic       func;
    logic [15:0] element_handle;
    logic [7:0]  agility;
    logic [1:0]  kind;
    logic        alive;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] head_handle;
    logic [11:0] head_priority;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [1:0]  status;
  } out_beat_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  // Broadcast to every cell of the chain in the cycle an operation commits.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctl_t;

  // Priority in tenths: agility * 15, 8 or 10; zero when not alive.
  function automatic logic [PRIO_W-1:0] prio_tenths(input logic [7:0] agility,
                                                    input logic [1:0] kind,
                                                    input logic       alive);
    logic [PRIO_W-1:0] a;
    logic [PRIO_W-1:0] p;
    a = PRIO_W'(agility);
    case (kind)
      KIND_AGILE: p = (a << 4) - a;
      KIND_TANK:  p = a << 3;
      default:    p = (a << 3) + (a << 1);
    endcase
    return alive ? p : '0;
  endfunction

endpackage

[hw/rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry, compares it with the new one
// and takes a neighbor's entry on insert or remove. Depends on spq_pkg.

module spq_cell (
  input  logic                   clk,
  input  spq_pkg::cell_ctl_t     ctl_i,
  input  logic                   occ_i,
  input  spq_pkg::entry_t        prev_entry_i,
  input  logic                   prev_keep_i,
  input  spq_pkg::entry_t        next_entry_i,
  output spq_pkg::entry_t        entry_o,
  output logic                   keep_o
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Entries at or above the new priority stay put; the chain is sorted, so
  // keep is high for a prefix of the cells.
  assign keep_o = occ_i && (entry_r.prio >= ctl_i.new_entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.enq) begin
      if (!keep_o) begin
        entry_nxt = prev_keep_i ? ctl_i.new_entry : prev_entry_i;
      end
    end else if (ctl_i.deq) begin
      entry_nxt = next_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue built as a chain of CAPACITY compare-and-shift cells.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel: drive in_data and raise start; a beat is taken at a rising
//   edge with start high and busy low. busy is always low: every cell
//   compares and shifts in the same cycle, so one beat is taken per cycle.
//   func enqueue inserts the element behind all entries of equal or higher
//   priority; func dequeue drops the head.
//   Result channel: out_valid is high for exactly one cycle, in the cycle after
//   the input beat, with the head entry, count, empty flag and status as
//   they stand after the operation. Throughput 1 beat/cycle.
//   Enqueue when full and dequeue when empty report status full / empty and
//   leave the queue as it was.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; stored slots are not cleared, the count alone marks them valid.

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  spq_pkg::in_beat_t  in_data,
  output logic               busy,
  output logic               out_valid,
  output spq_pkg::out_beat_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  logic [1:0]         status_r, status_nxt;
  logic               accept;
  logic               full, empty;
  spq_pkg::cell_ctl_t ctl;

  spq_pkg::entry_t    cell_entry [CAPACITY];
  logic               cell_keep  [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  always_comb begin
    ctl.enq                = 1'b0;
    ctl.deq                = 1'b0;
    ctl.new_entry.handle   = in_data.element_handle;
    ctl.new_entry.prio     = spq_pkg::prio_tenths(in_data.agility, in_data.kind,
                                                  in_data.alive);
    count_nxt              = count_r;
    status_nxt             = status_r;
    if (accept) begin
      status_nxt = spq_pkg::ST_DONE;
      if (in_data.func == spq_pkg::FUNC_ENQ) begin
        if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          ctl.enq   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          ctl.deq   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t prev_entry;
    spq_pkg::entry_t next_entry;
    logic            prev_keep;

    if (i == 0) begin : g_first
      assign prev_entry = ctl.new_entry;
      assign prev_keep  = 1'b1;
    end else begin : g_mid
      assign prev_entry = cell_entry[i-1];
      assign prev_keep  = cell_keep[i-1];
    end

    // The last slot's refill on dequeue lies past the count and is never read.
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = cell_entry[i];
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .occ_i        (count_r > CNT_W'(i)),
      .prev_entry_i (prev_entry),
      .prev_keep_i  (prev_keep),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[i]),
      .keep_o       (cell_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= spq_pkg::ST_DONE;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
      status_r    <= status_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.head_handle   = empty ? '0 : cell_entry[0].handle;
  assign out_data.head_priority = empty ? '0 : cell_entry[0].prio;
  assign out_data.entry_count   = 5'(count_r);
  assign out_data.is_empty      = empty;
  assign out_data.status        = status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == spq_pkg::ST_FULL) |-> full)
    else $error("full status while queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == spq_pkg::ST_EMPTY) |-> empty)
    else $error("empty status while queue not empty");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.func == spq_pkg::FUNC_ENQ) && !full |=>
      count_r == $past(count_r) + 1'b1)
    else $error("enqueue did not grow the count");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
    else $error("head below second entry");
`endif

endmodule

[dv/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: directed and random queue traffic.
// Depends on spq_pkg and the queue RTL; predicts every report and checks it field by field.

module tb_sorted_priority_queue;

  localparam int DEPTH = 16;
  localparam int RANDOM_BEATS = 1950;

  logic               clk;
  logic               rst_n;
  logic               start;
  spq_pkg::in_beat_t  in_data;
  logic               busy;
  logic               out_valid;
  spq_pkg::out_beat_t out_data;

  sorted_priority_queue #(
    .CAPACITY(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // shadow copy of the queue contents
  logic [15:0] q_handle [DEPTH];
  logic [11:0] q_prio   [DEPTH];
  int          q_count;

  spq_pkg::out_beat_t head_reports_due[$];
  int          errors;
  int          n_enq, n_deq, n_full, n_empty, n_checked, max_fill;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    q_count = 0;
    errors = 0;
    n_enq = 0;
    n_deq = 0;
    n_full = 0;
    n_empty = 0;
    n_checked = 0;
    max_fill = 0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [11:0] prio_of(input spq_pkg::in_beat_t b);
    logic [11:0] a;
    a = 12'(b.agility);
    if (!b.alive) return 12'd0;
    case (b.kind)
      spq_pkg::KIND_AGILE: return 12'(a * 15);
      spq_pkg::KIND_TANK:  return 12'(a * 8);
      default:             return 12'(a * 10);
    endcase
  endfunction

  // Applies one operation to the shadow queue and returns the report it yields.
  function automatic spq_pkg::out_beat_t queue_after_op(input spq_pkg::in_beat_t b);
    spq_pkg::out_beat_t r;
    logic [11:0]        p;
    int                 pos;
    int                 i;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    if (b.func == spq_pkg::FUNC_ENQ) begin
      if (q_count >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        p = prio_of(b);
        pos = 0;
        // new entry goes behind every entry of equal or higher priority
        while (pos < q_count && q_prio[pos] >= p) pos++;
        for (i = q_count; i > pos; i--) begin
          q_handle[i] = q_handle[i-1];
          q_prio[i] = q_prio[i-1];
        end
        q_handle[pos] = b.element_handle;
        q_prio[pos] = p;
        q_count++;
      end
    end else begin
      if (q_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        for (i = 0; i + 1 < q_count; i++) begin
          q_handle[i] = q_handle[i+1];
          q_prio[i] = q_prio[i+1];
        end
        q_count--;
      end
    end
    if (q_count > 0) begin
      r.head_handle = q_handle[0];
      r.head_priority = q_prio[0];
    end
    r.entry_count = 5'(q_count);
    r.is_empty = (q_count == 0);
    return r;
  endfunction

  function automatic spq_pkg::in_beat_t enq_beat(input logic [15:0] handle,
                                                 input logic [7:0]  agility,
                                                 input logic [1:0]  kind,
                                                 input logic        alive);
    spq_pkg::in_beat_t b;
    b.func = spq_pkg::FUNC_ENQ;
    b.element_handle = handle;
    b.agility = agility;
    b.kind = kind;
    b.alive = alive;
    return b;
  endfunction

  // Dequeue beat; the element fields carry junk since the block ignores them.
  function automatic spq_pkg::in_beat_t deq_beat();
    spq_pkg::in_beat_t b;
    b = spq_pkg::in_beat_t'($urandom);
    b.func = spq_pkg::FUNC_DEQ;
    return b;
  endfunction

  function automatic spq_pkg::in_beat_t random_beat(input int enq_pct);
    spq_pkg::in_beat_t b;
    if ($urandom_range(99, 0) >= enq_pct) return deq_beat();
    b.func = spq_pkg::FUNC_ENQ;
    b.element_handle = 16'($urandom);
    case ($urandom_range(3, 0))
      0: b.agility = 8'($urandom_range(4, 0) * 6);   // pool that collides across kinds
      1: b.agility = $urandom_range(1, 0) ? 8'd255 : 8'd0;
      default: b.agility = 8'($urandom);
    endcase
    b.kind = 2'($urandom_range(3, 0));
    b.alive = ($urandom_range(9, 0) != 0);
    return b;
  endfunction

  task automatic send_beat(input spq_pkg::in_beat_t b);
    spq_pkg::out_beat_t r;
    @(negedge clk);
    start <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = queue_after_op(b);
    head_reports_due.push_back(r);
    if (b.func == spq_pkg::FUNC_ENQ) n_enq++;
    else n_deq++;
    if (r.status == spq_pkg::ST_FULL) n_full++;
    if (r.status == spq_pkg::ST_EMPTY) n_empty++;
    if (q_count > max_fill) max_fill = q_count;
  endtask

  // start low, with noise on the data lines
  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= spq_pkg::in_beat_t'($urandom);
    end
  endtask

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_heads
    spq_pkg::out_beat_t want;
    if (rst_n && out_valid) begin
      if (head_reports_due.size() == 0) begin
        $error("result beat with no report pending");
        errors++;
      end else begin
        want = head_reports_due.pop_front();
        report_field("head_handle", want.head_handle, out_data.head_handle);
        report_field("head_priority", want.head_priority, out_data.head_priority);
        report_field("entry_count", want.entry_count, out_data.entry_count);
        report_field("is_empty", want.is_empty, out_data.is_empty);
        report_field("status", want.status, out_data.status);
        n_checked++;
      end
    end
  end

  task automatic test_empty_dequeue();
    send_beat(deq_beat());
  endtask

  // every kind at full agility, dead element, zero agility, both handle extremes
  task automatic test_priority_factors();
    send_beat(enq_beat(16'hFFFF, 8'd255, spq_pkg::KIND_OTHER, 1'b1));
    send_beat(enq_beat(16'h0001, 8'd255, spq_pkg::KIND_AGILE, 1'b1));
    send_beat(enq_beat(16'h0002, 8'd255, spq_pkg::KIND_TANK, 1'b1));
    send_beat(enq_beat(16'h0003, 8'd255, 2'd3, 1'b1));
    send_beat(enq_beat(16'h0004, 8'd255, spq_pkg::KIND_AGILE, 1'b0));
    send_beat(enq_beat(16'h0000, 8'd0, spq_pkg::KIND_AGILE, 1'b1));
  endtask

  // 360 tenths from three kinds: must leave in arrival order
  task automatic test_arrival_order();
    send_beat(enq_beat(16'h0A01, 8'd24, spq_pkg::KIND_AGILE, 1'b1));
    send_beat(enq_beat(16'h0A02, 8'd45, spq_pkg::KIND_TANK, 1'b1));
    send_beat(enq_beat(16'h0A03, 8'd36, spq_pkg::KIND_OTHER, 1'b1));
  endtask

  task automatic test_full_queue();
    while (q_count < DEPTH)
      send_beat(enq_beat(16'(16'hB000 + q_count), 8'(q_count * 7), 2'(q_count), 1'b1));
    send_beat(enq_beat(16'hBEEF, 8'd255, spq_pkg::KIND_AGILE, 1'b1));
    send_beat(deq_beat());
    send_beat(deq_beat());
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    int enq_pct;
    sent = 0;
    enq_pct = 50;
    while (sent < RANDOM_BEATS) begin
      // new fill bias now and then so the queue sweeps empty to full
      if ($urandom_range(7, 0) == 0) begin
        case ($urandom_range(2, 0))
          0: enq_pct = 15;
          1: enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      burst = $urandom_range(24, 1);
      repeat (burst) begin
        send_beat(random_beat(enq_pct));
        sent++;
      end
      if ($urandom_range(3, 0) != 0) pause($urandom_range(6, 1));
    end
    pause(1);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_dequeue();
    test_priority_factors();
    test_arrival_order();
    test_full_queue();
    test_random_traffic();
    while (head_reports_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Ran %0d enqueues and %0d dequeues, %0d reports checked, peak fill %0d.",
             n_enq, n_deq, n_checked, max_fill);
    $display("Saw %0d enqueues on a full queue and %0d dequeues on an empty one.",
             n_full, n_empty);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
